>>> sv/cache_miss_3c_classifier_macros.svh
// Assertion macros for the checker of the three-C miss classifier.
`ifndef CACHE_MISS_3C_CLASSIFIER_MACROS_SVH
`define CACHE_MISS_3C_CLASSIFIER_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define CM3C_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is also checked while reset is asserted.
`define CM3C_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cm3c_pkg.sv
// Types, constants and codes of the three-C miss classifier.
package cm3c_pkg;

  localparam int NUM_CORES    = 4;
  localparam int SHADOW_LINES = 64;
  localparam int BLOCK_BITS   = 16;

  // Fixed field widths.
  localparam int CORE_W    = 2;
  localparam int ADDR_W    = 32;
  localparam int CACHE_W   = 21;
  localparam int LINE_W    = 13;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES  = 1'd1;

  localparam logic [CACHE_W-1:0] CACHE_RESET = 21'd4096;
  localparam logic [LINE_W-1:0]  LINE_RESET  = 13'd64;

  // Shadow store geometry.
  localparam int SLOT_W   = (SHADOW_LINES > 1) ? $clog2(SHADOW_LINES) : 1;
  localparam int AGE_W    = SLOT_W;
  localparam int COUNT_W  = $clog2(SHADOW_LINES + 1);
  localparam int TAG_W    = BLOCK_BITS;
  localparam int SH_AW    = CORE_W + SLOT_W;
  localparam int SH_DEPTH = 1 << SH_AW;

  // Seen bitmap, stored as rows of 64 bits.
  localparam int SEEN_BIT_W = 6;
  localparam int SEEN_ROW_W = 1 << SEEN_BIT_W;
  localparam int SEEN_AW    = CORE_W + BLOCK_BITS - SEEN_BIT_W;
  localparam int SEEN_ROWS  = 1 << SEEN_AW;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = ADDR_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SEEN_RD,
    ST_SEEN_WR,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MC_NONE       = 2'd0,
    MC_COMPULSORY = 2'd1,
    MC_CONFLICT   = 2'd2,
    MC_CAPACITY   = 2'd3
  } miss_class_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } sh_word_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [AGE_W-1:0]  hit_age;
    logic              vic_any;
    logic [SLOT_W-1:0] vic_slot;
    logic [AGE_W-1:0]  vic_age;
    logic              free_any;
    logic [SLOT_W-1:0] free_slot;
  } scan_t;

endpackage

>>> sv/cache_miss_3c_classifier.sv
// Three-C miss classifier: seen bitmap memory plus per-core LRU shadow store memory.
// From accept to result valid, an item passes through the 32-step restoring divider and
// two one-slot-per-cycle sweeps of the shadow memory.
// An access that misses the shadow store and cannot insert (zero capacity) skips the second sweep.
// Items are taken one at a time; an out-of-range core skips the divider and the sweeps.
// Synchronous reset clears the seen bitmap in a pass over all SEEN_ROWS (4096) rows.
module cache_miss_3c_classifier
  import cm3c_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CORE_W-1:0]    in_core_id,
  input  logic [ADDR_W-1:0]    in_line_address,
  input  logic                 in_real_miss,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_miss_class,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CACHE_W-1:0] cache_bytes_r;
  logic [LINE_W-1:0]  line_bytes_r;

  logic [CORE_W-1:0]    core_r, core_nxt;
  logic                 miss_r, miss_nxt;
  logic [ADDR_W-1:0]    num_a_r, num_a_nxt;
  logic [ADDR_W-1:0]    num_c_r, num_c_nxt;
  logic [LINE_W-1:0]    div_r, div_nxt;
  logic [LINE_W-1:0]    rem_a_r, rem_a_nxt;
  logic [LINE_W-1:0]    rem_c_r, rem_c_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]   cap_r, cap_nxt;
  logic                 seen_r, seen_nxt;
  logic [SEEN_AW-1:0]   clr_r, clr_nxt;
  logic [SLOT_W:0]      ptr_r, ptr_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]    chk_slot_r, chk_slot_nxt;
  logic [SLOT_W-1:0]    ins_slot_r, ins_slot_nxt;
  scan_t                scan_r, scan_nxt;
  miss_class_t          class_r, class_nxt;
  logic                 out_valid_r, out_valid_nxt;
  miss_class_t          out_class_r, out_class_nxt;

  logic [SHADOW_LINES-1:0] vld_r   [NUM_CORES];
  logic [SHADOW_LINES-1:0] vld_nxt [NUM_CORES];
  logic [COUNT_W-1:0]      count_r   [NUM_CORES];
  logic [COUNT_W-1:0]      count_nxt [NUM_CORES];

  // Seen bitmap memory.
  logic [SEEN_ROW_W-1:0] seen_mem [SEEN_ROWS];
  logic                  seen_we, seen_re;
  logic [SEEN_AW-1:0]    seen_waddr, seen_raddr;
  logic [SEEN_ROW_W-1:0] seen_wdata, seen_rd_r;

  // Shadow tag and age memory, addressed by core and slot.
  sh_word_t           sh_mem [SH_DEPTH];
  logic               sh_we, sh_re;
  logic [SH_AW-1:0]   sh_waddr, sh_raddr;
  sh_word_t           sh_wdata, sh_rd_r;

  logic [LINE_W+1:0]  diff_a, diff_c;
  logic               neg_a, neg_c;
  logic [TAG_W-1:0]   block;
  logic [COUNT_W-1:0] cap_sat;
  logic               cur_vld;
  logic               evict;
  logic [SLOT_W-1:0]  ins_sel;
  logic               core_ok;

  // Restoring division step, shared counter for both dividends.
  assign diff_a = {1'b0, rem_a_r, num_a_r[ADDR_W-1]} - {2'b00, div_r};
  assign diff_c = {1'b0, rem_c_r, num_c_r[ADDR_W-1]} - {2'b00, div_r};
  assign neg_a  = diff_a[LINE_W+1];
  assign neg_c  = diff_c[LINE_W+1];

  // After the divider finishes, the dividend registers hold the quotients.
  assign block   = num_a_r[TAG_W-1:0];
  assign cap_sat = (num_c_r > ADDR_W'(SHADOW_LINES)) ? COUNT_W'(SHADOW_LINES)
                                                     : num_c_r[COUNT_W-1:0];

  assign cur_vld = vld_r[core_r][chk_slot_r];
  assign evict   = (count_r[core_r] >= cap_r) && scan_r.vic_any;
  assign ins_sel = !evict ? scan_r.free_slot :
                   (scan_r.free_any && (scan_r.free_slot < scan_r.vic_slot)) ?
                   scan_r.free_slot : scan_r.vic_slot;
  assign core_ok = int'(in_core_id) < NUM_CORES;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_miss_class = out_class_r;

  always_comb begin
    state_nxt     = state_r;
    core_nxt      = core_r;
    miss_nxt      = miss_r;
    num_a_nxt     = num_a_r;
    num_c_nxt     = num_c_r;
    div_nxt       = div_r;
    rem_a_nxt     = rem_a_r;
    rem_c_nxt     = rem_c_r;
    cnt_nxt       = cnt_r;
    cap_nxt       = cap_r;
    seen_nxt      = seen_r;
    clr_nxt       = clr_r;
    ptr_nxt       = ptr_r;
    chk_vld_nxt   = 1'b0;
    chk_slot_nxt  = chk_slot_r;
    ins_slot_nxt  = ins_slot_r;
    scan_nxt      = scan_r;
    class_nxt     = class_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_class_nxt = out_class_r;
    vld_nxt       = vld_r;
    count_nxt     = count_r;

    seen_we    = 1'b0;
    seen_re    = 1'b0;
    seen_waddr = {core_r, block[TAG_W-1:SEEN_BIT_W]};
    seen_raddr = {core_r, block[TAG_W-1:SEEN_BIT_W]};
    seen_wdata = seen_rd_r | (SEEN_ROW_W'(1) << block[SEEN_BIT_W-1:0]);
    sh_we      = 1'b0;
    sh_re      = 1'b0;
    sh_waddr   = {core_r, chk_slot_r};
    sh_raddr   = {core_r, ptr_r[SLOT_W-1:0]};
    sh_wdata   = sh_rd_r;

    case (state_r)
      ST_CLEAR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_r;
        seen_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          core_nxt  = in_core_id;
          miss_nxt  = in_real_miss;
          num_a_nxt = in_line_address;
          num_c_nxt = ADDR_W'(cache_bytes_r);
          div_nxt   = (line_bytes_r == '0) ? LINE_W'(1) : line_bytes_r;
          rem_a_nxt = '0;
          rem_c_nxt = '0;
          cnt_nxt   = '0;
          if (core_ok) begin
            state_nxt = ST_DIV;
          end else begin
            class_nxt = MC_NONE;
            state_nxt = ST_FIN;
          end
        end
      end

      ST_DIV: begin
        num_a_nxt = {num_a_r[ADDR_W-2:0], !neg_a};
        num_c_nxt = {num_c_r[ADDR_W-2:0], !neg_c};
        rem_a_nxt = neg_a ? {rem_a_r[LINE_W-2:0], num_a_r[ADDR_W-1]} : diff_a[LINE_W-1:0];
        rem_c_nxt = neg_c ? {rem_c_r[LINE_W-2:0], num_c_r[ADDR_W-1]} : diff_c[LINE_W-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SEEN_RD;
        end
      end

      ST_SEEN_RD: begin
        seen_re   = 1'b1;
        cap_nxt   = cap_sat;
        state_nxt = ST_SEEN_WR;
      end

      ST_SEEN_WR: begin
        seen_we   = 1'b1;
        seen_nxt  = seen_rd_r[block[SEEN_BIT_W-1:0]];
        ptr_nxt   = '0;
        scan_nxt  = '0;
        state_nxt = ST_SCAN;
      end

      ST_SCAN: begin
        // Reads run one slot ahead of the compare on the registered data.
        if (ptr_r < (SLOT_W+1)'(SHADOW_LINES)) begin
          sh_re        = 1'b1;
          ptr_nxt      = ptr_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_slot_nxt = ptr_r[SLOT_W-1:0];
        end else if (!chk_vld_r) begin
          state_nxt = ST_DECIDE;
        end
        if (chk_vld_r) begin
          if (cur_vld && (sh_rd_r.tag == block) && !scan_r.hit) begin
            scan_nxt.hit      = 1'b1;
            scan_nxt.hit_slot = chk_slot_r;
            scan_nxt.hit_age  = sh_rd_r.age;
          end
          // The first slot holding the largest age is the victim.
          if (cur_vld && (!scan_r.vic_any || (sh_rd_r.age > scan_r.vic_age))) begin
            scan_nxt.vic_any  = 1'b1;
            scan_nxt.vic_slot = chk_slot_r;
            scan_nxt.vic_age  = sh_rd_r.age;
          end
          if (!cur_vld && !scan_r.free_any) begin
            scan_nxt.free_any  = 1'b1;
            scan_nxt.free_slot = chk_slot_r;
          end
        end
      end

      ST_DECIDE: begin
        ptr_nxt = '0;
        if (!miss_r) begin
          class_nxt = MC_NONE;
        end else if (!seen_r) begin
          class_nxt = MC_COMPULSORY;
        end else if (scan_r.hit) begin
          class_nxt = MC_CONFLICT;
        end else begin
          class_nxt = MC_CAPACITY;
        end
        if (scan_r.hit) begin
          state_nxt = ST_UPDATE;
        end else if (cap_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          // Evict before insert: the freed victim slot may be the insert slot.
          if (evict) begin
            vld_nxt[core_r][scan_r.vic_slot] = 1'b0;
          end
          vld_nxt[core_r][ins_sel] = 1'b1;
          count_nxt[core_r] = evict ? count_r[core_r] : count_r[core_r] + 1'b1;
          ins_slot_nxt      = ins_sel;
          state_nxt         = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        if (ptr_r < (SLOT_W+1)'(SHADOW_LINES)) begin
          sh_re        = 1'b1;
          ptr_nxt      = ptr_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_slot_nxt = ptr_r[SLOT_W-1:0];
        end else if (!chk_vld_r) begin
          state_nxt = ST_FIN;
        end
        if (chk_vld_r) begin
          sh_we = 1'b1;
          if (scan_r.hit) begin
            if (chk_slot_r == scan_r.hit_slot) begin
              sh_wdata.age = '0;
            end else if (cur_vld && (sh_rd_r.age < scan_r.hit_age)) begin
              sh_wdata.age = sh_rd_r.age + 1'b1;
            end
          end else begin
            if (chk_slot_r == ins_slot_r) begin
              sh_wdata.tag = block;
              sh_wdata.age = '0;
            end else if (cur_vld) begin
              sh_wdata.age = sh_rd_r.age + 1'b1;
            end
          end
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = class_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r         <= '0;
      ptr_r         <= '0;
      chk_vld_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      cache_bytes_r <= CACHE_RESET;
      line_bytes_r  <= LINE_RESET;
      for (int i = 0; i < NUM_CORES; i++) begin
        vld_r[i]   <= '0;
        count_r[i] <= '0;
      end
    end else begin
      clr_r       <= clr_nxt;
      ptr_r       <= ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      count_r     <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CACHE_BYTES: cache_bytes_r <= cfg_wdata[CACHE_W-1:0];
          CFG_LINE_BYTES:  line_bytes_r  <= cfg_wdata[LINE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    core_r      <= core_nxt;
    miss_r      <= miss_nxt;
    num_a_r     <= num_a_nxt;
    num_c_r     <= num_c_nxt;
    div_r       <= div_nxt;
    rem_a_r     <= rem_a_nxt;
    rem_c_r     <= rem_c_nxt;
    cnt_r       <= cnt_nxt;
    cap_r       <= cap_nxt;
    seen_r      <= seen_nxt;
    chk_slot_r  <= chk_slot_nxt;
    ins_slot_r  <= ins_slot_nxt;
    scan_r      <= scan_nxt;
    class_r     <= class_nxt;
    out_class_r <= out_class_nxt;
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    if (seen_re) begin
      seen_rd_r <= seen_mem[seen_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sh_we) begin
      sh_mem[sh_waddr] <= sh_wdata;
    end
    if (sh_re) begin
      sh_rd_r <= sh_mem[sh_raddr];
    end
  end

endmodule

>>> sv/cm3c_checker.sv
// Port-level checker for the three-C miss classifier and its bind statement.
`include "cache_miss_3c_classifier_macros.svh"

module cm3c_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_miss_class
);

  // Reset starts the clearing pass, so nothing is taken or shown right after it.
  `CM3C_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !in_ready && !out_valid, "busy after reset")

  // Items are worked on one at a time.
  `CM3C_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready after accept")

  // Even the shortest path passes through ST_FIN and the result register before its result shows.
  `CM3C_ASSERT(a_min_latency, clk, rst_n, in_valid && in_ready |=> !$rose(out_valid), "result too early")

  `CM3C_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_miss_class), "stalled result changed")

endmodule

bind cache_miss_3c_classifier cm3c_checker u_cm3c_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_miss_class (out_miss_class)
);
